>>> rtl/kdb_pkg.sv
// ---------------------------------------------------------------------------
// kdb_pkg
// shared widths, register indexes and types for the key debouncer
// ---------------------------------------------------------------------------
package kdb_pkg;

    localparam int unsigned KEY_COUNT  = 4;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned HELD_W     = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0]    DEBOUNCE_RESET   = 8'd20;
    localparam logic [HELD_W-1:0]     HOLD_LIMIT_RESET = 16'd1000;
    localparam logic [COUNT_W-1:0]    COUNT_MAX        = '1;
    localparam logic [HELD_W-1:0]     HELD_MAX         = '1;

    localparam logic [CFG_IDX_W-1:0]  REG_DEBOUNCE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_HOLD_LIMIT   = 1'd1;

    typedef logic [KEY_COUNT-1:0] t_keys;

    // per-key controls from the debounce stage to a hold counter
    typedef struct packed {
        logic advance;
        logic rise;
        logic pressed;
        logic reported;
    } t_key_ctl;

endpackage

>>> rtl/kdb_in_if.sv
// ---------------------------------------------------------------------------
// kdb_in_if
// tick channel: raw key levels and take masks
// ---------------------------------------------------------------------------
interface kdb_in_if
    import kdb_pkg::*;
;
    logic  valid;
    logic  ready;
    t_keys raw_keys;
    t_keys take_down_mask;
    t_keys take_up_mask;
    t_keys take_long_mask;

    modport source (output valid, raw_keys, take_down_mask, take_up_mask,
                    take_long_mask, input ready);
    modport sink   (input valid, raw_keys, take_down_mask, take_up_mask,
                    take_long_mask, output ready);
endinterface

>>> rtl/kdb_out_if.sv
// ---------------------------------------------------------------------------
// kdb_out_if
// result channel: debounced state, taken and pending event flags
// ---------------------------------------------------------------------------
interface kdb_out_if
    import kdb_pkg::*;
;
    logic  valid;
    logic  ready;
    t_keys stable_keys;
    t_keys down_taken;
    t_keys up_taken;
    t_keys long_taken;
    t_keys down_pending;
    t_keys up_pending;
    t_keys long_pending;

    modport source (output valid, stable_keys, down_taken, up_taken, long_taken,
                    down_pending, up_pending, long_pending, input ready);
    modport sink   (input valid, stable_keys, down_taken, up_taken, long_taken,
                    down_pending, up_pending, long_pending, output ready);
endinterface

>>> rtl/kdb_key_hold.sv
// ---------------------------------------------------------------------------
// kdb_key_hold
// per-key held-time counter with long press detection
// ---------------------------------------------------------------------------
module kdb_key_hold
    import kdb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_key_ctl          i_ctl,
    input  logic [HELD_W-1:0] i_long_ticks,
    output logic              o_long_set
);

    logic [HELD_W-1:0] r_held;
    logic [HELD_W-1:0] n_held;

    always_comb begin
        n_held = r_held;
        if (i_ctl.rise) begin
            n_held = '0;
        end else if (i_ctl.pressed && r_held != HELD_MAX) begin
            n_held = r_held + 1'b1;
        end
    end

    // one report per press, on the updated count
    assign o_long_set = i_ctl.pressed && !i_ctl.reported && (n_held >= i_long_ticks);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_ctl.advance) begin
            r_held <= n_held;
        end
    end

endmodule

>>> rtl/key_debounce_press_events_top.sv
// ---------------------------------------------------------------------------
// key_debounce_press_events_top
// four-key debouncer with sticky down, up and long press flags
// ---------------------------------------------------------------------------
//   channel   | direction | transfer contents
//   ----------+-----------+-----------------------------------------------
//   i_in      | in        | raw_keys and the down, up and long take masks
//   o_out     | out       | stable_keys, three taken and three pending sets
//   i_cfg_*   | in        | register write, index 0 debounce, 1 long press
//
// one transfer per cycle sustained while o_out.ready stays high; a tick passes
// through the input register and then the result register
// the event state updates as a tick leaves the input register
// reset is synchronous, active low; valid flags and event state clear, config returns to
// its reset values (debounce 20, long press 1000)
// a stalled result holds the result register, then the input register
// fills and i_in.ready drops
module key_debounce_press_events_top
    import kdb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    kdb_in_if.sink                i_in,
    kdb_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [COUNT_W-1:0] r_debounce_ticks;
    logic [HELD_W-1:0]  r_long_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= DEBOUNCE_RESET;
            r_long_ticks     <= HOLD_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE:   r_debounce_ticks <= i_cfg_data[COUNT_W-1:0];
                REG_HOLD_LIMIT: r_long_ticks     <= i_cfg_data[HELD_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic  r_s1_valid;
    t_keys r_raw;
    t_keys r_take_down;
    t_keys r_take_up;
    t_keys r_take_long;
    logic  r_out_valid;
    logic  s1_adv;
    logic  in_xfer;

    assign s1_adv      = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_adv;
    assign in_xfer     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_raw       <= i_in.raw_keys;
            r_take_down <= i_in.take_down_mask;
            r_take_up   <= i_in.take_up_mask;
            r_take_long <= i_in.take_long_mask;
        end
    end

    // debounce and event state
    t_keys              r_cand;
    logic [COUNT_W-1:0] r_count;
    t_keys              r_stable;
    t_keys              r_down;
    t_keys              r_up;
    t_keys              r_long;
    t_keys              r_reported;

    logic [COUNT_W-1:0] n_count;
    logic               accept;
    t_keys              diff;
    t_keys              rise;
    t_keys              fall;
    t_keys              n_stable;
    t_keys              down_mid;
    t_keys              up_mid;
    t_keys              rep_mid;
    t_keys              long_set;
    t_keys              long_mid;
    t_keys              down_taken;
    t_keys              up_taken;
    t_keys              long_taken;
    t_keys              n_down;
    t_keys              n_up;
    t_keys              n_long;
    t_keys              n_reported;

    always_comb begin
        // a changed raw vector restarts the quiet count, which saturates
        if (r_raw != r_cand) begin
            n_count = '0;
        end else if (r_count != COUNT_MAX) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = r_count;
        end

        // candidate (now the raw vector) is taken once it has been quiet long enough
        accept   = (r_raw != r_stable) && (n_count >= r_debounce_ticks);
        diff     = r_stable ^ r_raw;
        rise     = accept ? (r_raw & diff) : '0;
        fall     = accept ? (~r_raw & diff) : '0;
        n_stable = accept ? r_raw : r_stable;

        down_mid = r_down | rise;
        up_mid   = r_up | fall;
        rep_mid  = r_reported & ~(rise | fall);

        // take masks return and clear after the update
        down_taken = down_mid & r_take_down;
        up_taken   = up_mid & r_take_up;
        n_down     = down_mid & ~r_take_down;
        n_up       = up_mid & ~r_take_up;
    end

    // long press flags come back from the hold counters
    always_comb begin
        long_mid   = r_long | long_set;
        long_taken = long_mid & r_take_long;
        n_long     = long_mid & ~r_take_long;
        n_reported = rep_mid | long_set;
    end

    // one held-time counter per key
    for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
        t_key_ctl key_ctl;

        // advance, rise, pressed, reported
        assign key_ctl = {s1_adv, rise[k], n_stable[k], rep_mid[k]};

        kdb_key_hold u_hold (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (key_ctl),
            .i_long_ticks (r_long_ticks),
            .o_long_set   (long_set[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand     <= '0;
            r_count    <= '0;
            r_stable   <= '0;
            r_down     <= '0;
            r_up       <= '0;
            r_long     <= '0;
            r_reported <= '0;
        end else if (s1_adv) begin
            r_cand     <= r_raw;
            r_count    <= n_count;
            r_stable   <= n_stable;
            r_down     <= n_down;
            r_up       <= n_up;
            r_long     <= n_long;
            r_reported <= n_reported;
        end
    end

    // result register
    t_keys r_o_stable;
    t_keys r_o_down_taken;
    t_keys r_o_up_taken;
    t_keys r_o_long_taken;
    t_keys r_o_down_pend;
    t_keys r_o_up_pend;
    t_keys r_o_long_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_stable     <= n_stable;
            r_o_down_taken <= down_taken;
            r_o_up_taken   <= up_taken;
            r_o_long_taken <= long_taken;
            r_o_down_pend  <= n_down;
            r_o_up_pend    <= n_up;
            r_o_long_pend  <= n_long;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.stable_keys  = r_o_stable;
    assign o_out.down_taken   = r_o_down_taken;
    assign o_out.up_taken     = r_o_up_taken;
    assign o_out.long_taken   = r_o_long_taken;
    assign o_out.down_pending = r_o_down_pend;
    assign o_out.up_pending   = r_o_up_pend;
    assign o_out.long_pending = r_o_long_pend;

    // a long press is only remembered for a key that is still held
    a_reported_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_reported & ~r_stable) == '0)
        else $error("long press marked on a released key");

    // the debounced state only ever moves to the candidate vector
    a_stable_from_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stable != $past(r_stable)) |-> (r_stable == r_cand))
        else $error("stable state changed to a vector other than the candidate");

    // a flag is either returned or left pending, never both
    a_take_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (((r_o_down_taken & r_o_down_pend) == '0) &&
                         ((r_o_up_taken & r_o_up_pend) == '0) &&
                         ((r_o_long_taken & r_o_long_pend) == '0)))
        else $error("flag both taken and still pending");

endmodule

>>> bench/key_debounce_press_events_top_tb.sv
// ---------------------------------------------------------------------------
// key_debounce_press_events_top_tb
// self-checking bench for the four-key debouncer with event latches
// ---------------------------------------------------------------------------
// ticks go in through the input channel in bursts with random gaps, and
// results are taken under a changing stall pattern; an event predictor
// inside a small scoreboard works out each expected report as a tick is
// accepted, and every report is compared field by field, in order
// register settings change only while the block is idle, from the reset
// values through zero and short debounce and long press counts, ending
// with holds at the largest debounce count, where the quiet counter saturates
// ---------------------------------------------------------------------------
module key_debounce_press_events_top_tb;
    import kdb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned SETTLE_CYCLES = 6;   // settle wait after the last report, with margin
    localparam int unsigned HOLD_OFF_AT = 350;   // tick count that starts the long stall
    localparam int unsigned HOLD_OFF_LEN = 300;

    // one tick as it is offered on the input channel
    typedef struct packed {
        t_keys raw;
        t_keys take_down;
        t_keys take_up;
        t_keys take_long;
    } t_key_tick;

    // one report as it leaves the block
    typedef struct packed {
        t_keys stable;
        t_keys down_taken;
        t_keys up_taken;
        t_keys long_taken;
        t_keys down_pending;
        t_keys up_pending;
        t_keys long_pending;
    } t_key_report;

    // -----------------------------------------------------------------------
    // event predictor and store of the reports still to come
    // -----------------------------------------------------------------------
    class press_event_board;
        logic [COUNT_W-1:0] debounce;
        logic [HELD_W-1:0]  hold_limit;

        t_keys              candidate;
        logic [COUNT_W-1:0] still_count;
        t_keys              stable;
        t_keys              down_fl;
        t_keys              up_fl;
        t_keys              long_fl;
        t_keys              reported;
        logic [HELD_W-1:0]  held [KEY_COUNT];

        t_key_report        expected_reports[$];
        int unsigned        ticks_noted;
        int unsigned        errors;

        function new();
            debounce    = DEBOUNCE_RESET;
            hold_limit  = HOLD_LIMIT_RESET;
            candidate   = '0;
            still_count = '0;
            stable      = '0;
            down_fl     = '0;
            up_fl       = '0;
            long_fl     = '0;
            reported    = '0;
            foreach (held[k]) held[k] = '0;
            ticks_noted = 0;
            errors      = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_DEBOUNCE) begin
                debounce = val[COUNT_W-1:0];
            end else if (idx == REG_HOLD_LIMIT) begin
                hold_limit = val[HELD_W-1:0];
            end
        endfunction

        // advance the event state by one tick and queue the report it yields
        function void note_tick(t_key_tick t);
            t_keys       diff;
            t_keys       rise;
            t_keys       fall;
            t_key_report r;

            rise = '0;
            fall = '0;
            if (t.raw != candidate) begin
                candidate   = t.raw;
                still_count = '0;
            end else if (still_count != COUNT_MAX) begin
                still_count++;
            end

            if (candidate != stable && still_count >= debounce) begin
                diff     = stable ^ candidate;
                rise     = candidate & diff;
                fall     = ~candidate & diff;
                stable   = candidate;
                down_fl  |= rise;
                up_fl    |= fall;
                reported &= ~(rise | fall);
            end

            for (int k = 0; k < KEY_COUNT; k++) begin
                if (rise[k]) begin
                    held[k] = '0;
                end else if (stable[k] && held[k] != HELD_MAX) begin
                    held[k]++;
                end
                if (stable[k] && !reported[k] && held[k] >= hold_limit) begin
                    long_fl[k]  = 1'b1;
                    reported[k] = 1'b1;
                end
            end

            r.stable       = stable;
            r.down_taken   = down_fl & t.take_down;
            r.up_taken     = up_fl & t.take_up;
            r.long_taken   = long_fl & t.take_long;
            down_fl        &= ~r.down_taken;
            up_fl          &= ~r.up_taken;
            long_fl        &= ~r.long_taken;
            r.down_pending = down_fl;
            r.up_pending   = up_fl;
            r.long_pending = long_fl;
            expected_reports.push_back(r);
            ticks_noted++;
        endfunction

        function void compare_field(string name, t_keys want, t_keys got);
            if (want !== got) begin
                $error("%s mismatch: expected %h, got %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_key_report got);
            t_key_report want;

            if (expected_reports.size() == 0) begin
                $error("report with no tick outstanding: %h", got);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            compare_field("stable_keys", want.stable, got.stable);
            compare_field("down_taken", want.down_taken, got.down_taken);
            compare_field("up_taken", want.up_taken, got.up_taken);
            compare_field("long_taken", want.long_taken, got.long_taken);
            compare_field("down_pending", want.down_pending, got.down_pending);
            compare_field("up_pending", want.up_pending, got.up_pending);
            compare_field("long_pending", want.long_pending, got.long_pending);
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // clock, channels, block
    // -----------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    kdb_in_if  in_ch ();
    kdb_out_if out_ch ();

    press_event_board board = new();
    t_key_report      seen_report;
    int unsigned      cycle_count = 0;
    int unsigned      burst_left = 1;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    key_debounce_press_events_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // -----------------------------------------------------------------------
    // watchdog: a hung handshake must not run forever
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("key_debounce_press_events_top test failed");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // result monitor: every transfer on the output is checked in order
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen_report.stable       = out_ch.stable_keys;
            seen_report.down_taken   = out_ch.down_taken;
            seen_report.up_taken     = out_ch.up_taken;
            seen_report.long_taken   = out_ch.long_taken;
            seen_report.down_pending = out_ch.down_pending;
            seen_report.up_pending   = out_ch.up_pending;
            seen_report.long_pending = out_ch.long_pending;
            board.check_result(seen_report);
        end
    end

    // -----------------------------------------------------------------------
    // receiver: switches between random stall patterns; once, part way through
    // the run, it holds off long enough for the block to back up its input
    // -----------------------------------------------------------------------
    initial begin
        int unsigned stall_mode;
        int unsigned phase_cnt;
        bit          held_off;

        out_ch.ready = 1'b0;
        stall_mode   = 0;
        phase_cnt    = 0;
        held_off     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_off && board.ticks_noted >= HOLD_OFF_AT) begin
                // long hold-off while the sender keeps offering ticks
                held_off     = 1'b1;
                out_ch.ready = 1'b0;
                repeat (HOLD_OFF_LEN) @(negedge i_clk);
            end else begin
                if (phase_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
                phase_cnt++;
                case (stall_mode)
                    0: out_ch.ready = 1'b1;
                    1: out_ch.ready = 1'($urandom_range(0, 1));
                    2: out_ch.ready = (phase_cnt % 4 != 0);
                    default: out_ch.ready = ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // -----------------------------------------------------------------------
    // stimulus helpers; all are entered and left at a falling edge
    // -----------------------------------------------------------------------
    function automatic t_keys pick_mask();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 5) return '0;        // let flags pile up
        if (r < 8) return '1;
        return t_keys'($urandom_range(0, 15));
    endfunction

    // offer one tick, hold it until the transfer, then maybe leave a gap
    task automatic offer_tick(input t_key_tick t);
        int unsigned gap;

        in_ch.valid          = 1'b1;
        in_ch.raw_keys       = t.raw;
        in_ch.take_down_mask = t.take_down;
        in_ch.take_up_mask   = t.take_up;
        in_ch.take_long_mask = t.take_long;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_tick(t);
        @(negedge i_clk);

        burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // quiet the sender and wait for every outstanding report
    task automatic drain();
        in_ch.valid = 1'b0;
        while (board.expected_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
        board.set_register(idx, val);
    endtask

    // debounce register only keeps the low byte; junk goes in the upper one
    task automatic set_timing(input int unsigned deb, input int unsigned lp);
        write_reg(REG_DEBOUNCE, {8'($urandom_range(0, 255)), 8'(deb)});
        write_reg(REG_HOLD_LIMIT, 16'(lp));
    endtask

    // key patterns held for runs around the debounce and long press counts,
    // with contact bounce at the start of a run and some plain noise
    task automatic run_presses(input int unsigned n_ticks);
        t_key_tick   t;
        t_keys       target;
        int unsigned run_left;
        int unsigned age;
        int unsigned deb;
        int unsigned span;

        target   = board.stable;
        run_left = 0;
        age      = 0;
        for (int unsigned i = 0; i < n_ticks; i++) begin
            if (run_left == 0) begin
                if ($urandom_range(0, 2) != 0)
                    target = target ^ t_keys'(1 << $urandom_range(0, KEY_COUNT - 1));
                else
                    target = t_keys'($urandom_range(0, 15));
                deb  = board.debounce;
                span = deb + board.hold_limit + 6;
                if (span > 80) span = 80;
                if ($urandom_range(0, 9) == 0)
                    run_left = $urandom_range(1, deb + 1);      // short glitch, at most deb + 1 ticks long
                else
                    run_left = $urandom_range(deb + 1, (span > deb + 1) ? span : deb + 1);
                age = 0;
            end
            t.raw = target;
            if (age < 3 && $urandom_range(0, 2) == 0)
                t.raw = target ^ t_keys'($urandom_range(1, 15));
            if ($urandom_range(0, 19) == 0)
                t.raw = t_keys'($urandom_range(0, 15));
            t.take_down = pick_mask();
            t.take_up   = pick_mask();
            t.take_long = pick_mask();
            offer_tick(t);
            run_left--;
            age++;
        end
    endtask

    task automatic hold_steady(input t_keys level, input int unsigned n_ticks);
        t_key_tick t;

        for (int unsigned i = 0; i < n_ticks; i++) begin
            t.raw       = level;
            t.take_down = pick_mask();
            t.take_up   = pick_mask();
            t.take_long = pick_mask();
            offer_tick(t);
        end
    endtask

    // directed ticks for zero debounce and a one-tick long press:
    // {raw, take down, take up, take long}
    localparam logic [15:0] DIRECTED [21] = '{
        16'hF000, 16'hF000, 16'hF0FF, 16'hFF00, 16'h0000, 16'h0F0F, 16'hA000,
        16'h5000, 16'h5842, 16'h0000, 16'h0FFF, 16'h1000, 16'h2000, 16'h4000,
        16'h8000, 16'h8F00, 16'h0000, 16'hF000, 16'hF000, 16'hF000, 16'h0FFF
    };

    // -----------------------------------------------------------------------
    // main sequence
    // -----------------------------------------------------------------------
    initial begin
        in_ch.valid          = 1'b0;
        in_ch.raw_keys       = '0;
        in_ch.take_down_mask = '0;
        in_ch.take_up_mask   = '0;
        in_ch.take_long_mask = '0;

        // synchronous reset held low from the start, released at a falling edge
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset timing: debounce 20, long press 1000
        run_presses(100);
        drain();

        // zero debounce accepts on the same tick; one-tick long press
        set_timing(0, 1);
        foreach (DIRECTED[i]) offer_tick(t_key_tick'(DIRECTED[i]));
        drain();

        // zero long press count flags a press on the tick it is accepted
        write_reg(REG_HOLD_LIMIT, 16'd0);
        run_presses(50);
        drain();

        // short timings so debounce and long press both happen often;
        // the receiver's long hold-off lands in this phase
        set_timing(3, 8);
        run_presses(350);
        drain();

        set_timing(1, 2);
        run_presses(130);
        drain();

        set_timing(7, 40);
        run_presses(80);
        drain();

        // largest debounce count: the quiet counter reaches its top value
        // as the held vector is accepted and stays there while it is held
        set_timing(255, 40);
        hold_steady('1, 256 + 60);
        hold_steady('0, 260);
        drain();

        if (board.errors == 0 && board.expected_reports.size() == 0) begin
            $display("key_debounce_press_events_top test passed");
        end else begin
            $display("key_debounce_press_events_top test failed");
        end
        $finish;
    end

endmodule
